// ----- src/ppu_sau_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_sau_pkg
// Types, codes and address helpers shared by the scroll address unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_sau_pkg;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  localparam logic [8:0] DOT_LAST       = 9'd340;
  localparam logic [8:0] DOT_SKIP       = 9'd339;
  localparam logic [8:0] DOT_FLAG       = 9'd1;
  localparam logic [8:0] DOT_FETCH_END  = 9'd256;
  localparam logic [8:0] DOT_HCOPY      = 9'd257;
  localparam logic [8:0] DOT_VCOPY_LO   = 9'd280;
  localparam logic [8:0] DOT_VCOPY_HI   = 9'd304;
  localparam logic [8:0] DOT_PREF_LO    = 9'd321;
  localparam logic [8:0] DOT_PREF_HI    = 9'd336;
  localparam logic [8:0] LINE_LAST      = 9'd261;
  localparam logic [8:0] LINE_VISIBLE   = 9'd240;
  localparam logic [8:0] LINE_VBLANK    = 9'd241;
  localparam logic [8:0] DOT_RESET      = 9'd340;
  localparam logic [8:0] LINE_RESET     = 9'd240;

  localparam logic [14:0] HORIZ_BITS    = 15'h041F;
  localparam logic [14:0] VERT_BITS     = 15'h7BE0;
  localparam logic [4:0]  COARSE_Y_WRAP = 5'd29;
  localparam logic [4:0]  COARSE_Y_MAX  = 5'd31;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] reg_index;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic [14:0] vram_address;
    logic [13:0] tile_fetch_address;
    logic [13:0] attribute_fetch_address;
    logic [2:0]  fine_x_scroll;
    logic        data_access_valid;
    logic        data_access_is_write;
    logic [13:0] data_access_address;
    logic [7:0]  read_data;
    logic        nmi_request;
    logic [8:0]  dot_position;
    logic [8:0]  scanline_position;
  } result_t;

  typedef struct packed {
    logic [14:0] v;
    logic [14:0] t;
    logic [2:0]  fine_x;
    logic        toggle;
    logic [7:0]  ctrl;
    logic [7:0]  mask;
    logic        vblank;
    logic [8:0]  dot;
    logic [8:0]  line;
    logic        odd;
  } state_t;

  function automatic logic [14:0] coarse_x_step(input logic [14:0] a);
    logic [14:0] r;
    r = a;
    if (a[4:0] == 5'h1F) begin
      r[4:0] = 5'd0;
      r[10]  = ~a[10];
    end else begin
      r[4:0] = a[4:0] + 5'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] fine_y_step(input logic [14:0] a);
    logic [14:0] r;
    r = a;
    if (a[14:12] != 3'h7) begin
      r[14:12] = a[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (a[9:5] == COARSE_Y_WRAP) begin
        r[9:5] = 5'd0;
        r[11]  = ~a[11];
      end else if (a[9:5] == COARSE_Y_MAX) begin
        r[9:5] = 5'd0;
      end else begin
        r[9:5] = a[9:5] + 5'd1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/ppu_sau_if.sv -----
// ----------------------------------------------------------------------------
// ppu_sau_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ppu_sau_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [2:0] reg_index;
  logic [7:0] write_value;

  modport source(output valid, operation, reg_index, write_value, input ready);
  modport sink(input valid, operation, reg_index, write_value, output ready);
endinterface

interface ppu_sau_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] vram_address;
  logic [13:0] tile_fetch_address;
  logic [13:0] attribute_fetch_address;
  logic [2:0]  fine_x_scroll;
  logic        data_access_valid;
  logic        data_access_is_write;
  logic [13:0] data_access_address;
  logic [7:0]  read_data;
  logic        nmi_request;
  logic [8:0]  dot_position;
  logic [8:0]  scanline_position;

  modport source(output valid, vram_address, tile_fetch_address, attribute_fetch_address,
                 fine_x_scroll, data_access_valid, data_access_is_write,
                 data_access_address, read_data, nmi_request, dot_position,
                 scanline_position, input ready);
  modport sink(input valid, vram_address, tile_fetch_address, attribute_fetch_address,
               fine_x_scroll, data_access_valid, data_access_is_write,
               data_access_address, read_data, nmi_request, dot_position,
               scanline_position, output ready);
endinterface

`default_nettype wire

// ----- src/ppu_sau_regs.sv -----
// ----------------------------------------------------------------------------
// ppu_sau_regs
// Scroll/address state and its single-pass next-state logic per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_sau_regs import ppu_sau_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  output result_t       result
);

  state_t      s;
  state_t      s_next;
  logic [8:0]  tick_dot;
  logic [8:0]  tick_line;
  logic        tick_odd;
  logic [14:0] tick_v;
  logic        rendering;
  logic        fetch_dot;
  logic [14:0] data_inc_v;
  logic        acc_valid;
  logic        acc_write;
  logic [13:0] acc_addr;
  logic [7:0]  rdata;

  assign rendering  = s.mask[3] | s.mask[4];
  assign data_inc_v = s.v + (s.ctrl[2] ? 15'd32 : 15'd1);

  always_comb begin
    tick_dot  = s.dot + 9'd1;
    tick_line = s.line;
    tick_odd  = s.odd;
    if (s.line == LINE_LAST && s.dot == DOT_SKIP && rendering && s.odd) begin
      tick_dot  = 9'd0;
      tick_line = 9'd0;
      tick_odd  = ~s.odd;
    end else if (s.dot >= DOT_LAST) begin
      tick_dot = 9'd0;
      if (s.line >= LINE_LAST) begin
        tick_line = 9'd0;
        tick_odd  = ~s.odd;
      end else begin
        tick_line = s.line + 9'd1;
      end
    end
  end

  always_comb begin
    fetch_dot = ((tick_dot >= 9'd1) && (tick_dot <= DOT_FETCH_END)) ||
                ((tick_dot >= DOT_PREF_LO) && (tick_dot <= DOT_PREF_HI));
    tick_v = s.v;
    if (rendering && ((tick_line < LINE_VISIBLE) || (tick_line == LINE_LAST))) begin
      if (fetch_dot && (tick_dot[2:0] == 3'd0)) begin
        tick_v = coarse_x_step(tick_v);
      end
      if (tick_dot == DOT_FETCH_END) begin
        tick_v = fine_y_step(tick_v);
      end
      if (tick_dot == DOT_HCOPY) begin
        tick_v = (tick_v & ~HORIZ_BITS) | (s.t & HORIZ_BITS);
      end
      if (tick_line == LINE_LAST && tick_dot >= DOT_VCOPY_LO && tick_dot <= DOT_VCOPY_HI) begin
        tick_v = (tick_v & ~VERT_BITS) | (s.t & VERT_BITS);
      end
    end
  end

  always_comb begin
    s_next    = s;
    acc_valid = 1'b0;
    acc_write = 1'b0;
    acc_addr  = 14'd0;
    rdata     = 8'd0;
    case (op_t'(item.operation))
      OP_WRITE: begin
        case (item.reg_index)
          REG_CTRL: begin
            s_next.ctrl     = item.write_value;
            s_next.t[11:10] = item.write_value[1:0];
          end
          REG_MASK: begin
            s_next.mask = item.write_value;
          end
          REG_SCROLL: begin
            if (!s.toggle) begin
              s_next.t[4:0]  = item.write_value[7:3];
              s_next.fine_x  = item.write_value[2:0];
            end else begin
              s_next.t[9:5]   = item.write_value[7:3];
              s_next.t[14:12] = item.write_value[2:0];
            end
            s_next.toggle = ~s.toggle;
          end
          REG_ADDR: begin
            if (!s.toggle) begin
              s_next.t[13:8] = item.write_value[5:0];
              s_next.t[14]   = 1'b0;
            end else begin
              s_next.t[7:0] = item.write_value;
              s_next.v      = {s.t[14:8], item.write_value};
            end
            s_next.toggle = ~s.toggle;
          end
          REG_DATA: begin
            acc_valid = 1'b1;
            acc_write = 1'b1;
            acc_addr  = s.v[13:0];
            s_next.v  = data_inc_v;
          end
          default: begin
          end
        endcase
      end
      OP_READ: begin
        case (item.reg_index)
          REG_STATUS: begin
            rdata         = {s.vblank, 7'd0};
            s_next.vblank = 1'b0;
            s_next.toggle = 1'b0;
          end
          REG_DATA: begin
            acc_valid = 1'b1;
            acc_addr  = s.v[13:0];
            s_next.v  = data_inc_v;
          end
          default: begin
          end
        endcase
      end
      OP_TICK: begin
        s_next.dot  = tick_dot;
        s_next.line = tick_line;
        s_next.odd  = tick_odd;
        s_next.v    = tick_v;
        if (tick_line == LINE_VBLANK && tick_dot == DOT_FLAG) begin
          s_next.vblank = 1'b1;
        end
        if (tick_line == LINE_LAST && tick_dot == DOT_FLAG) begin
          s_next.vblank = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.vram_address            = s_next.v;
    result.tile_fetch_address      = {2'b10, s_next.v[11:0]};
    result.attribute_fetch_address = {2'b10, s_next.v[11:10], 4'b1111,
                                      s_next.v[9:7], s_next.v[4:2]};
    result.fine_x_scroll           = s_next.fine_x;
    result.data_access_valid       = acc_valid;
    result.data_access_is_write    = acc_write;
    result.data_access_address     = acc_addr;
    result.read_data               = rdata;
    result.nmi_request             = s_next.vblank & s_next.ctrl[7];
    result.dot_position            = s_next.dot;
    result.scanline_position       = s_next.line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s.v      <= 15'd0;
      s.t      <= 15'd0;
      s.fine_x <= 3'd0;
      s.toggle <= 1'b0;
      s.ctrl   <= 8'd0;
      s.mask   <= 8'd0;
      s.vblank <= 1'b0;
      s.dot    <= DOT_RESET;
      s.line   <= LINE_RESET;
      s.odd    <= 1'b0;
    end else if (accept) begin
      s <= s_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/ppu_sau_out.sv -----
// ----------------------------------------------------------------------------
// ppu_sau_out
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_sau_out import ppu_sau_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire result_t in_result,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_result
);

  logic valid;
  logic valid_next;

  assign in_ready   = !valid || out_ready;
  assign valid_next = in_valid || (valid && !out_ready);
  assign out_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_result <= in_result;
    end
  end

endmodule

`default_nettype wire

// ----- src/ppu_scroll_address_unit.sv -----
// ----------------------------------------------------------------------------
// ppu_scroll_address_unit
// Scroll and VRAM address registers with dot/scanline timing.
// ----------------------------------------------------------------------------
// Timing: an accepted beat's result beat is valid in the cycle after it.
// Throughput: 1 beat per cycle unless the sink stalls; each beat's next state
// and result, formed in one combinational pass, land in state/result registers.
// Reset: synchronous; dot 340, line 240, all other state zero, no result held.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_scroll_address_unit import ppu_sau_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  ppu_sau_in_if.sink  in_ch,
  ppu_sau_out_if.source out_ch
);

  in_item_t item;
  result_t  result;
  result_t  held;
  logic     accept;
  logic     ready;

  assign item.operation   = in_ch.operation;
  assign item.reg_index   = in_ch.reg_index;
  assign item.write_value = in_ch.write_value;
  assign in_ch.ready      = ready;
  assign accept           = in_ch.valid && ready;

  ppu_sau_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .result (result)
  );

  ppu_sau_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (ready),
    .in_result  (result),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (held)
  );

  assign out_ch.vram_address            = held.vram_address;
  assign out_ch.tile_fetch_address      = held.tile_fetch_address;
  assign out_ch.attribute_fetch_address = held.attribute_fetch_address;
  assign out_ch.fine_x_scroll           = held.fine_x_scroll;
  assign out_ch.data_access_valid       = held.data_access_valid;
  assign out_ch.data_access_is_write    = held.data_access_is_write;
  assign out_ch.data_access_address     = held.data_access_address;
  assign out_ch.read_data               = held.read_data;
  assign out_ch.nmi_request             = held.nmi_request;
  assign out_ch.dot_position            = held.dot_position;
  assign out_ch.scanline_position       = held.scanline_position;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("accepted beat produced no result beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while result beat stalled");

  a_data_access: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.reg_index == REG_DATA &&
     (in_ch.operation == OP_WRITE || in_ch.operation == OP_READ))
    |=> (out_ch.data_access_valid &&
         out_ch.data_access_is_write == ($past(in_ch.operation) == OP_WRITE)))
    else $error("data port beat without matching access");

endmodule

`default_nettype wire
